// ===== src/x86_64_instruction_length_cover_unit_assert.svh =====
// assertion macros for the instruction length cover unit
`ifndef X86_64_INSTRUCTION_LENGTH_COVER_UNIT_ASSERT_SVH
`define X86_64_INSTRUCTION_LENGTH_COVER_UNIT_ASSERT_SVH
// implication checked on every edge outside reset
`define ILC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ilc check failed");
// next-cycle implication checked outside reset
`define ILC_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ilc check failed");
`endif

// ===== src/ilc_pkg.sv =====
// shared types, constants and opcode tables of the instruction length cover unit
package ilc_pkg;
  localparam int WindowBytes = 64;
  localparam int LenW = 7;
  localparam int QDepth = 2;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_UNKNOWN = 2'd1;
  localparam logic [1:0] ST_WINDOW = 2'd2;
  localparam logic [1:0] ST_LIMITS = 2'd3;

  localparam logic [0:0] CFG_MIN_COVER = 1'b0;
  localparam logic [0:0] CFG_MAX_WINDOW = 1'b1;

  localparam logic [2:0] PH_PREFIX = 3'd0;
  localparam logic [2:0] PH_ESCAPE = 3'd1;
  localparam logic [2:0] PH_MODRM = 3'd2;
  localparam logic [2:0] PH_SIB = 3'd3;
  localparam logic [2:0] PH_TAIL = 3'd4;

  localparam logic [7:0] F_M = 8'h01;
  localparam logic [7:0] F_B = 8'h02;
  localparam logic [7:0] F_W = 8'h04;
  localparam logic [7:0] F_D = 8'h08;
  localparam logic [7:0] F_R = 8'h10;
  localparam logic [7:0] F_L = 8'h20;
  localparam logic [7:0] F_X = 8'h80;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       start_scan;
  } item_t;

  typedef struct packed {
    logic [LenW-1:0] cover_length;
    logic [1:0]      status;
  } result_t;

  // byte class worked out by the front part
  typedef struct packed {
    logic       is_prefix;
    logic       is_rex;
    logic       rex_w;
    logic       is_esc;
    logic       is_3byte;
    logic [7:0] map1;
    logic [7:0] map2;
  } class_t;

  typedef struct packed {
    item_t  item;
    class_t cls;
  } qent_t;

  function automatic logic [7:0] one_byte_map(input logic [7:0] b);
    logic [7:0] f;
    logic [3:0] lo;
    lo = b[3:0];
    f = F_X;
    unique case (b[7:4])
      4'h0, 4'h1, 4'h2, 4'h3: begin
        if (lo[2:0] <= 3'd3) f = F_M;
        else if (lo[2:0] == 3'd4) f = F_B;
        else if (lo[2:0] == 3'd5) f = F_D;
        else f = F_X;
      end
      4'h4: f = F_X;
      4'h5: f = 8'h00;
      4'h6: begin
        unique case (lo)
          4'h3: f = F_M;
          4'h8: f = F_D;
          4'h9: f = F_M | F_D;
          4'hA: f = F_B;
          4'hB: f = F_M | F_B;
          default: f = F_X;
        endcase
      end
      4'h7: f = F_R;
      4'h8: begin
        unique case (lo)
          4'h0, 4'h3: f = F_M | F_B;
          4'h1: f = F_M | F_D;
          4'h2: f = F_X;
          default: f = F_M;
        endcase
      end
      4'h9: f = (lo == 4'hA) ? F_X : 8'h00;
      4'hA: begin
        if (lo <= 4'h3) f = F_X;
        else if (lo == 4'h8) f = F_B;
        else if (lo == 4'h9) f = F_D;
        else f = 8'h00;
      end
      4'hB: f = lo[3] ? F_D : F_B;
      4'hC: begin
        unique case (lo)
          4'h0, 4'h1, 4'h6: f = F_M | F_B;
          4'h2: f = F_W;
          4'h7: f = F_M | F_D;
          4'h4, 4'h5, 4'h8, 4'hA, 4'hE: f = F_X;
          4'hD: f = F_B;
          default: f = 8'h00;
        endcase
      end
      4'hD: f = (lo <= 4'h3) ? F_M : F_X;
      4'hE: begin
        if (lo <= 4'h3) f = F_R;
        else if (lo <= 4'h7) f = F_B;
        else if (lo <= 4'h9) f = F_L;
        else if (lo == 4'hA) f = F_X;
        else if (lo == 4'hB) f = F_R;
        else f = 8'h00;
      end
      4'hF: begin
        unique case (lo)
          4'h0, 4'h2, 4'h3: f = F_X;
          4'h6: f = F_M | F_B;
          4'h7: f = F_M | F_D;
          4'hE, 4'hF: f = F_M;
          default: f = 8'h00;
        endcase
      end
      default: f = F_X;
    endcase
    return f;
  endfunction

  function automatic logic [7:0] two_byte_map(input logic [7:0] b);
    logic [7:0] f;
    logic [3:0] lo;
    lo = b[3:0];
    f = F_M;
    unique case (b[7:4])
      4'h0: begin
        if (lo <= 4'h3 || lo >= 4'hE) f = F_M;
        else if (lo <= 4'h7 || lo == 4'hA || lo == 4'hC || lo == 4'hD) f = F_X;
        else f = 8'h00;
      end
      4'h1: f = (lo == 4'h7) ? F_X : F_M;
      4'h2: f = (lo == 4'h6 || lo == 4'h7) ? F_X : F_M;
      4'h3: f = (lo <= 4'h5) ? 8'h00 : F_X;
      4'h7: begin
        if (lo <= 4'h3 || (lo >= 4'h8 && lo <= 4'hB)) f = F_M | F_B;
        else if (lo == 4'h7) f = 8'h00;
        else f = F_M;
      end
      4'h8: f = F_L;
      4'hA: begin
        unique case (lo)
          4'h0, 4'h1, 4'h2, 4'h8, 4'h9: f = 8'h00;
          4'h4, 4'hC: f = F_M | F_B;
          default: f = F_M;
        endcase
      end
      4'hB: begin
        if (lo == 4'h8 || lo == 4'h9) f = F_X;
        else if (lo == 4'hA) f = F_M | F_B;
        else f = F_M;
      end
      4'hC: begin
        if (lo[3]) f = 8'h00;
        else if (lo == 4'h2 || lo == 4'h4 || lo == 4'h5 || lo == 4'h6) f = F_M | F_B;
        else f = F_M;
      end
      4'hF: f = (lo == 4'hF) ? F_X : F_M;
      default: f = F_M;
    endcase
    return f;
  endfunction
endpackage

// ===== src/ilc_stream_if.sv =====
// valid/ready channel carrying one payload
interface ilc_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== src/ilc_front.sv =====
// front part: classifies each code byte and queues it
module ilc_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ilc_pkg::item_t      in_item,
  output logic                q_valid,
  input  logic                q_ready,
  output ilc_pkg::qent_t      q_ent
);
  import ilc_pkg::*;

  qent_t            mem_r [QDepth];
  logic             wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0]       cnt_r, cnt_nxt;
  qent_t            ent;
  logic             push, pop;
  logic [7:0]       b;

  always_comb begin
    b = in_item.code_byte;
    ent.item = in_item;
    ent.cls.is_prefix = (b == 8'h66) || (b == 8'h67) || (b == 8'hF0) || (b == 8'hF2) ||
                        (b == 8'hF3) || (b == 8'h26) || (b == 8'h2E) || (b == 8'h36) ||
                        (b == 8'h3E) || (b == 8'h64) || (b == 8'h65);
    ent.cls.is_rex = (b[7:4] == 4'h4);
    ent.cls.rex_w = b[3];
    ent.cls.is_esc = (b == 8'h0F);
    ent.cls.is_3byte = (b == 8'h38) || (b == 8'h3A);
    ent.cls.map1 = one_byte_map(b);
    ent.cls.map2 = two_byte_map(b);
  end

  assign in_ready = (cnt_r != 2'(QDepth));
  assign q_valid = (cnt_r != 2'd0);
  assign q_ent = mem_r[rp_r];
  assign push = in_valid && in_ready;
  assign pop = q_valid && q_ready;

  always_comb begin
    wp_nxt = push ? ~wp_r : wp_r;
    rp_nxt = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r <= wp_nxt;
      rp_r <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= ent;
  end
endmodule

// ===== src/ilc_back.sv =====
// back part: instruction walk and result register
module ilc_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_valid,
  output logic                        q_ready,
  input  ilc_pkg::qent_t              q_ent,
  input  logic [ilc_pkg::LenW-1:0]    min_cover,
  input  logic [ilc_pkg::LenW-1:0]    max_window,
  output logic                        out_valid,
  input  logic                        out_ready,
  output ilc_pkg::result_t            out_res
);
  import ilc_pkg::*;

  logic            act_r, act_nxt;
  logic [LenW-1:0] off_r, off_nxt;
  logic [2:0]      ph_r, ph_nxt;
  logic            rexw_r, rexw_nxt;
  logic            esc_r, esc_nxt;
  logic [7:0]      opc_r, opc_nxt;
  logic [7:0]      flg_r, flg_nxt;
  logic [3:0]      left_r, left_nxt;
  logic            ov_r;
  result_t         res_r;
  logic            emit;
  result_t         res;
  logic            take;

  function automatic logic [3:0] imm_size(input logic [7:0] f, input logic e,
                                          input logic w, input logic [7:0] op);
    logic [3:0] s;
    if ((f & F_B) != 8'h00) s = 4'd1;
    else if ((f & F_W) != 8'h00) s = 4'd2;
    else if ((f & F_D) != 8'h00)
      s = (!e && w && op >= 8'hB8 && op <= 8'hBF) ? 4'd8 : 4'd4;
    else if ((f & F_R) != 8'h00) s = 4'd1;
    else if ((f & F_L) != 8'h00) s = 4'd4;
    else s = 4'd0;
    return s;
  endfunction

  assign q_ready = !ov_r || out_ready;
  assign take = q_valid && q_ready;
  assign out_valid = ov_r;
  assign out_res = res_r;

  always_comb begin
    logic [7:0] b;
    logic       done;
    logic       stop;
    logic [7:0] fl;
    logic [1:0] md;
    logic [2:0] rm;
    logic [3:0] disp;
    logic [LenW-1:0] o1;
    b = q_ent.item.code_byte;
    done = 1'b0;
    stop = 1'b0;
    fl = 8'h00;
    md = b[7:6];
    rm = b[2:0];
    disp = 4'd0;
    o1 = off_r;
    act_nxt = act_r; off_nxt = off_r; ph_nxt = ph_r; rexw_nxt = rexw_r;
    esc_nxt = esc_r; opc_nxt = opc_r; flg_nxt = flg_r; left_nxt = left_r;
    emit = 1'b0;
    res = '0;
    if (q_ent.item.start_scan) begin
      act_nxt = 1'b0; off_nxt = '0; ph_nxt = PH_PREFIX; rexw_nxt = 1'b0;
      esc_nxt = 1'b0; opc_nxt = '0; flg_nxt = '0; left_nxt = '0;
      if (min_cover == '0 || max_window == '0 || min_cover > max_window ||
          max_window > LenW'(WindowBytes)) begin
        emit = 1'b1; res.status = ST_LIMITS; stop = 1'b1;
      end else begin
        act_nxt = 1'b1;
      end
    end
    if (!stop && act_nxt) begin
      if (off_nxt >= max_window) begin
        emit = 1'b1; res.status = ST_WINDOW; act_nxt = 1'b0;
      end else begin
        unique case (ph_nxt)
          PH_PREFIX: begin
            if (q_ent.cls.is_prefix) begin
            end else if (q_ent.cls.is_rex) begin
              rexw_nxt = q_ent.cls.rex_w;
            end else if (q_ent.cls.is_esc) begin
              ph_nxt = PH_ESCAPE;
            end else begin
              opc_nxt = b;
              fl = q_ent.cls.map1;
              if ((fl & F_X) != 8'h00) begin
                emit = 1'b1; res.status = ST_UNKNOWN; stop = 1'b1;
              end
            end
          end
          PH_ESCAPE: begin
            esc_nxt = 1'b1;
            opc_nxt = b;
            fl = q_ent.cls.map2;
            if (q_ent.cls.is_3byte || (fl & F_X) != 8'h00) begin
              emit = 1'b1; res.status = ST_UNKNOWN; stop = 1'b1;
            end
          end
          PH_MODRM: begin
            if (md == 2'd0) disp = (rm == 3'd5) ? 4'd4 : 4'd0;
            else if (md == 2'd1) disp = 4'd1;
            else if (md == 2'd2) disp = 4'd4;
            if (md != 2'd3 && rm == 3'd4) begin
              left_nxt = disp; ph_nxt = PH_SIB;
            end else begin
              left_nxt = disp + imm_size(flg_nxt, esc_nxt, rexw_nxt, opc_nxt);
              ph_nxt = PH_TAIL;
              done = (left_nxt == 4'd0);
            end
          end
          PH_SIB: begin
            disp = left_nxt;
            if (disp == 4'd0 && rm == 3'd5) disp = 4'd4;
            left_nxt = disp + imm_size(flg_nxt, esc_nxt, rexw_nxt, opc_nxt);
            ph_nxt = PH_TAIL;
            done = (left_nxt == 4'd0);
          end
          default: begin
            if (left_nxt != 4'd0) left_nxt = left_nxt - 4'd1;
            done = (left_nxt == 4'd0);
          end
        endcase
        if (!stop && (ph_nxt == ph_r || q_ent.item.start_scan) && ph_nxt != PH_ESCAPE &&
            ph_nxt != PH_MODRM && ph_nxt != PH_SIB && ph_nxt != PH_TAIL) begin
          // prefix phase byte that was an opcode
          if (!q_ent.cls.is_prefix && !q_ent.cls.is_rex && !q_ent.cls.is_esc) begin
            flg_nxt = fl;
            if ((fl & F_M) != 8'h00) ph_nxt = PH_MODRM;
            else begin
              left_nxt = imm_size(fl, esc_nxt, rexw_nxt, opc_nxt);
              ph_nxt = PH_TAIL;
              done = (left_nxt == 4'd0);
            end
          end
        end else if (!stop && ph_nxt == PH_ESCAPE && esc_nxt) begin
          flg_nxt = fl;
          if ((fl & F_M) != 8'h00) ph_nxt = PH_MODRM;
          else begin
            left_nxt = imm_size(fl, 1'b1, rexw_nxt, opc_nxt);
            ph_nxt = PH_TAIL;
            done = (left_nxt == 4'd0);
          end
        end
        if (stop) begin
          act_nxt = 1'b0;
        end else begin
          o1 = off_nxt + LenW'(1);
          off_nxt = o1;
          if (done && o1 >= min_cover) begin
            emit = 1'b1; res.status = ST_OK; res.cover_length = o1; act_nxt = 1'b0;
          end else begin
            if (done) begin
              ph_nxt = PH_PREFIX; rexw_nxt = 1'b0; esc_nxt = 1'b0;
              opc_nxt = '0; flg_nxt = '0; left_nxt = '0;
            end
            if (o1 >= max_window) begin
              emit = 1'b1; res.status = ST_WINDOW; act_nxt = 1'b0;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0; off_r <= '0; ph_r <= PH_PREFIX; rexw_r <= 1'b0;
      esc_r <= 1'b0; opc_r <= '0; flg_r <= '0; left_r <= '0; ov_r <= 1'b0;
    end else begin
      if (take) begin
        act_r <= act_nxt; off_r <= off_nxt; ph_r <= ph_nxt; rexw_r <= rexw_nxt;
        esc_r <= esc_nxt; opc_r <= opc_nxt; flg_r <= flg_nxt; left_r <= left_nxt;
      end
      if (take && emit) ov_r <= 1'b1;
      else if (out_ready) ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) res_r <= res;
  end
endmodule

// ===== src/x86_64_instruction_length_cover_unit.sv =====
// x86-64 instruction length cover unit: finds the shortest run of whole
// instructions covering min_cover bytes, one code byte per transfer. A byte
// is classified in the front part (prefix, rex, escape, opcode table lookup)
// and queued in a two-entry queue; the back part walks the instruction phases
// and owns a result register, so one byte is taken every cycle while the
// result channel is ready. A result that is not taken stalls the back part,
// and the queue then fills and holds off the input after two more bytes.
// From byte transfer to result, a byte passes the queue entry and then the
// result register; earlier bytes still waiting in the queue add to the wait.
module x86_64_instruction_length_cover_unit (
  input  logic                     clk,
  input  logic                     rst_n,
  ilc_stream_if.sink               in_ch,
  ilc_stream_if.source             out_ch,
  input  logic                     cfg_we,
  input  logic                     cfg_index,
  input  logic [ilc_pkg::LenW-1:0] cfg_data
);
  import ilc_pkg::*;

  logic            q_valid, q_ready;
  qent_t           q_ent;
  logic [LenW-1:0] min_cover_r, max_window_r;

  // live limit registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_cover_r <= LenW'(5);
      max_window_r <= LenW'(WindowBytes);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MIN_COVER: min_cover_r <= cfg_data;
        CFG_MAX_WINDOW: max_window_r <= cfg_data;
        default: ;
      endcase
    end
  end

  ilc_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_item(in_ch.payload),
    .q_valid(q_valid), .q_ready(q_ready), .q_ent(q_ent)
  );

  ilc_back u_back (
    .clk(clk), .rst_n(rst_n),
    .q_valid(q_valid), .q_ready(q_ready), .q_ent(q_ent),
    .min_cover(min_cover_r), .max_window(max_window_r),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_res(out_ch.payload)
  );
endmodule

// ===== src/ilc_checker.sv =====
// port-level checker for the instruction length cover unit
module ilc_checker (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     out_valid,
  input logic                     out_ready,
  input ilc_pkg::result_t         out_payload
);
  import ilc_pkg::*;
`include "x86_64_instruction_length_cover_unit_assert.svh"

  `ILC_ASSERT_IMP(a_fail_zero, out_valid && out_payload.status != ST_OK, out_payload.cover_length == '0)
  `ILC_ASSERT_IMP(a_ok_len, out_valid && out_payload.status == ST_OK, out_payload.cover_length != '0)
  `ILC_ASSERT_NXT(a_hold, out_valid && !out_ready, out_valid && $stable(out_payload))
endmodule

bind x86_64_instruction_length_cover_unit ilc_checker u_chk (
  .clk(clk), .rst_n(rst_n), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_payload(out_ch.payload)
);

// ===== tb/sv/x86_64_instruction_length_cover_unit_tb.sv =====
// self-checking testbench for the x86-64 instruction length cover unit
`timescale 1ns / 1ps

module x86_64_instruction_length_cover_unit_tb;
  import ilc_pkg::*;

  // opcode class flags, short forms for the tables below
  localparam logic [7:0] M = F_M;
  localparam logic [7:0] B = F_B;
  localparam logic [7:0] W = F_W;
  localparam logic [7:0] D = F_D;
  localparam logic [7:0] R = F_R;
  localparam logic [7:0] L = F_L;
  localparam logic [7:0] X = F_X;
  localparam logic [7:0] MB = F_M | F_B;
  localparam logic [7:0] MD = F_M | F_D;

  localparam int CycleLimit = 400000;
  localparam int DrainCycles = 8;
  localparam int HoldCycles = 300;
  localparam int PhaseBytes = 75;

  localparam logic [7:0] OneMap [256] = '{
    M,M,M,M,B,D,X,X, M,M,M,M,B,D,X,X,
    M,M,M,M,B,D,X,X, M,M,M,M,B,D,X,X,
    M,M,M,M,B,D,X,X, M,M,M,M,B,D,X,X,
    M,M,M,M,B,D,X,X, M,M,M,M,B,D,X,X,
    X,X,X,X,X,X,X,X, X,X,X,X,X,X,X,X,
    0,0,0,0,0,0,0,0, 0,0,0,0,0,0,0,0,
    X,X,X,M,X,X,X,X, D,MD,B,MB,X,X,X,X,
    R,R,R,R,R,R,R,R, R,R,R,R,R,R,R,R,
    MB,MD,X,MB,M,M,M,M, M,M,M,M,M,M,M,M,
    0,0,0,0,0,0,0,0, 0,0,X,0,0,0,0,0,
    X,X,X,X,0,0,0,0, B,D,0,0,0,0,0,0,
    B,B,B,B,B,B,B,B, D,D,D,D,D,D,D,D,
    MB,MB,W,0,X,X,MB,MD, X,0,X,0,0,B,X,0,
    M,M,M,M,X,X,X,X, X,X,X,X,X,X,X,X,
    R,R,R,R,B,B,B,B, L,L,X,R,0,0,0,0,
    X,0,X,X,0,0,MB,MD, 0,0,0,0,0,0,M,M
  };

  localparam logic [7:0] TwoMap [256] = '{
    M,M,M,M,X,X,X,X, 0,0,X,0,X,X,M,M,
    M,M,M,M,M,M,M,X, M,M,M,M,M,M,M,M,
    M,M,M,M,M,M,X,X, M,M,M,M,M,M,M,M,
    0,0,0,0,0,0,X,X, X,X,X,X,X,X,X,X,
    M,M,M,M,M,M,M,M, M,M,M,M,M,M,M,M,
    M,M,M,M,M,M,M,M, M,M,M,M,M,M,M,M,
    M,M,M,M,M,M,M,M, M,M,M,M,M,M,M,M,
    MB,MB,MB,MB,M,M,M,0, MB,MB,MB,MB,M,M,M,M,
    L,L,L,L,L,L,L,L, L,L,L,L,L,L,L,L,
    M,M,M,M,M,M,M,M, M,M,M,M,M,M,M,M,
    0,0,0,M,MB,M,M,M, 0,0,M,M,MB,M,M,M,
    M,M,M,M,M,M,M,M, X,X,MB,M,M,M,M,M,
    M,M,MB,M,MB,MB,MB,M, 0,0,0,0,0,0,0,0,
    M,M,M,M,M,M,M,M, M,M,M,M,M,M,M,M,
    M,M,M,M,M,M,M,M, M,M,M,M,M,M,M,M,
    M,M,M,M,M,M,M,M, M,M,M,M,M,M,M,X
  };

  localparam logic [7:0] LegacyPrefix [11] = '{
    8'h66, 8'h67, 8'hF0, 8'hF2, 8'hF3, 8'h26, 8'h2E, 8'h36, 8'h3E, 8'h64, 8'h65
  };

  // immediate bytes of an opcode, shared by the length tracker and the code builder
  function automatic int imm_bytes(logic [7:0] flags, bit esc, logic [7:0] op, bit wide);
    if (flags & F_B) return 1;
    if (flags & F_W) return 2;
    if (flags & F_D) return (!esc && wide && op >= 8'hB8 && op <= 8'hBF) ? 8 : 4;
    if (flags & F_R) return 1;
    if (flags & F_L) return 4;
    return 0;
  endfunction

  // tracks the scan, holds the cover lengths still to arrive
  class cover_scoreboard;
    int unsigned min_cover = 5;
    int unsigned max_window = 64;
    bit active;
    int unsigned offset;
    logic [2:0] phase;
    bit wide;
    bit esc;
    logic [7:0] op;
    logic [7:0] flags;
    int unsigned left;
    result_t pending_q[$];
    int errors;

    function void clear_instr();
      phase = PH_PREFIX;
      wide = 0;
      esc = 0;
      op = 0;
      flags = 0;
      left = 0;
    endfunction

    function void finish_scan(int unsigned len, logic [1:0] st);
      result_t r;
      r.cover_length = len[LenW-1:0];
      r.status = st;
      pending_q.push_back(r);
      active = 0;
    endfunction

    // opcode taken: returns 1 when the instruction is complete
    function bit take_opcode(logic [7:0] f);
      flags = f;
      if (f & F_M) begin
        phase = PH_MODRM;
        return 0;
      end
      left = imm_bytes(flags, esc, op, wide);
      phase = PH_TAIL;
      return left == 0;
    endfunction

    function void note_transfer(item_t it);
      logic [7:0] b;
      bit done;
      int unsigned disp;
      b = it.code_byte;
      done = 0;
      if (it.start_scan) begin
        active = 0;
        offset = 0;
        clear_instr();
        if (min_cover == 0 || max_window == 0 || min_cover > max_window ||
            max_window > WindowBytes) begin
          finish_scan(0, ST_LIMITS);
          return;
        end
        active = 1;
      end
      if (!active) return;
      if (offset >= max_window) begin
        finish_scan(0, ST_WINDOW);
        return;
      end
      case (phase)
        PH_PREFIX: begin
          if (b inside {LegacyPrefix}) begin
            // legacy prefix skipped
          end else if (b >= 8'h40 && b <= 8'h4F) begin
            wide = b[3];
          end else if (b == 8'h0F) begin
            phase = PH_ESCAPE;
          end else begin
            op = b;
            if (OneMap[b] & F_X) begin
              finish_scan(0, ST_UNKNOWN);
              return;
            end
            done = take_opcode(OneMap[b]);
          end
        end
        PH_ESCAPE: begin
          if (b == 8'h38 || b == 8'h3A || (TwoMap[b] & F_X)) begin
            finish_scan(0, ST_UNKNOWN);
            return;
          end
          esc = 1;
          op = b;
          done = take_opcode(TwoMap[b]);
        end
        PH_MODRM: begin
          case (b[7:6])
            2'd0: disp = (b[2:0] == 3'd5) ? 4 : 0;
            2'd1: disp = 1;
            2'd2: disp = 4;
            default: disp = 0;
          endcase
          if (b[7:6] != 2'd3 && b[2:0] == 3'd4) begin
            left = disp;
            phase = PH_SIB;
          end else begin
            left = disp + imm_bytes(flags, esc, op, wide);
            phase = PH_TAIL;
            done = left == 0;
          end
        end
        PH_SIB: begin
          // no displacement yet means mod 0, where base 5 brings a disp32
          if (left == 0 && b[2:0] == 3'd5) left = 4;
          left += imm_bytes(flags, esc, op, wide);
          phase = PH_TAIL;
          done = left == 0;
        end
        default: begin
          if (left > 0) left--;
          done = left == 0;
        end
      endcase
      offset++;
      if (done) begin
        if (offset >= min_cover) begin
          finish_scan(offset, ST_OK);
          return;
        end
        clear_instr();
      end
      if (offset >= max_window) finish_scan(0, ST_WINDOW);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result: len %0d status %0d",
                                   got.cover_length, got.status);
        return;
      end
      want = pending_q.pop_front();
      if (got.cover_length !== want.cover_length || got.status !== want.status) begin
        errors++;
        if (errors <= 10)
          $display("result mismatch: expected len %0d status %0d, got len %0d status %0d",
                   want.cover_length, want.status, got.cover_length, got.status);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_index;
  logic [LenW-1:0] cfg_data;

  ilc_stream_if #(.payload_t(item_t)) in_ch ();
  ilc_stream_if #(.payload_t(result_t)) out_ch ();

  x86_64_instruction_length_cover_unit dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch.sink),
    .out_ch(out_ch.source),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  cover_scoreboard sb;
  item_t code_q[$];   // bytes waiting to be sent
  int burst_left;
  int cycle_count;
  int sent_count;
  bit hold_req;
  int hold_left;
  int stall_mode;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // receiver: stall pattern changes now and then, long hold-off on request
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req = 0;
      hold_left = HoldCycles;
    end
    if ($urandom_range(0, 63) == 0) stall_mode = $urandom_range(0, 3);
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      case (stall_mode)
        0: out_ch.ready <= 1'b1;                              // no stalls
        1: out_ch.ready <= ($urandom_range(0, 3) != 0);
        2: out_ch.ready <= ($urandom_range(0, 1) != 0);
        default: out_ch.ready <= ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  // result transfers checked at the rising edge
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) sb.check_result(out_ch.payload);
  end

  // drive one byte; valid stays high into the next byte unless a gap follows
  task automatic send_byte(item_t it, bit last);
    in_ch.valid = 1'b1;
    in_ch.payload = it;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_transfer(it);
    sent_count++;
    @(negedge clk);
    if (burst_left > 0) burst_left--;
    if (last || burst_left == 0) begin
      in_ch.valid = 1'b0;
      if (burst_left == 0) begin
        repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 8) : 0) @(negedge clk);
        burst_left = ($urandom_range(0, 3) == 0) ? 1000 : $urandom_range(1, 12);
      end
    end
  endtask

  task automatic flush_code();
    item_t it;
    while (code_q.size() > 0) begin
      it = code_q.pop_front();
      send_byte(it, code_q.size() == 0);
    end
  endtask

  task automatic push_bytes(bit first, input logic [7:0] b []);
    item_t it;
    foreach (b[i]) begin
      it.code_byte = b[i];
      it.start_scan = first && i == 0;
      code_q.push_back(it);
    end
  endtask

  // wait for every expected result, then let the pipeline settle
  task automatic drain();
    while (sb.pending_q.size() > 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, int unsigned val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val[LenW-1:0];
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == CFG_MIN_COVER) sb.min_cover = val;
    else sb.max_window = val;
  endtask

  task automatic set_limits(int unsigned mc, int unsigned mw);
    drain();
    write_reg(CFG_MIN_COVER, mc);
    write_reg(CFG_MAX_WINDOW, mw);
  endtask

  // append one well-formed instruction with random content, returns its length
  function automatic int add_instruction(bit first);
    logic [7:0] op;
    logic [7:0] f;
    logic [7:0] modrm;
    logic [7:0] sib;
    bit esc;
    bit wide;
    int n;
    int disp;
    item_t it;
    logic [7:0] bytes_q[$];
    wide = 0;
    repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0)
      bytes_q.push_back(LegacyPrefix[4'($urandom_range(0, 10))]);
    if ($urandom_range(0, 2) == 0) begin
      op = 8'h40 | 8'($urandom_range(0, 15));
      wide = op[3];
      bytes_q.push_back(op);
    end
    esc = ($urandom_range(0, 4) == 0);
    if (esc) begin
      bytes_q.push_back(8'h0F);
      do op = 8'($urandom_range(0, 255));
      while ((TwoMap[op] & F_X) || op == 8'h38 || op == 8'h3A);
      f = TwoMap[op];
    end else begin
      // mov with imm64 often, to exercise rex.w widening
      if ($urandom_range(0, 7) == 0) op = 8'hB8 | 8'($urandom_range(0, 7));
      else do op = 8'($urandom_range(0, 255)); while (OneMap[op] & F_X);
      f = OneMap[op];
    end
    bytes_q.push_back(op);
    disp = 0;
    if (f & F_M) begin
      modrm = 8'($urandom_range(0, 255));
      bytes_q.push_back(modrm);
      case (modrm[7:6])
        2'd0: disp = (modrm[2:0] == 3'd5) ? 4 : 0;
        2'd1: disp = 1;
        2'd2: disp = 4;
        default: disp = 0;
      endcase
      if (modrm[7:6] != 2'd3 && modrm[2:0] == 3'd4) begin
        sib = 8'($urandom_range(0, 255));
        bytes_q.push_back(sib);
        if (modrm[7:6] == 2'd0 && sib[2:0] == 3'd5) disp = 4;
      end
    end
    n = disp + imm_bytes(f, esc, op, wide);
    repeat (n) bytes_q.push_back(8'($urandom_range(0, 255)));
    foreach (bytes_q[i]) begin
      it.code_byte = bytes_q[i];
      it.start_scan = first && i == 0;
      code_q.push_back(it);
    end
    return bytes_q.size();
  endfunction

  // one scan: mostly whole instructions, sometimes noise or a cut-off run
  task automatic random_scan();
    int len;
    int target;
    item_t it;
    if ($urandom_range(0, 15) == 0) begin
      // stray bytes, ignored when no scan is running
      it.code_byte = 8'($urandom_range(0, 255));
      it.start_scan = 0;
      code_q.push_back(it);
    end
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 10)) begin
        it.code_byte = 8'($urandom_range(0, 255));
        it.start_scan = code_q.size() == 0 || $urandom_range(0, 9) == 0;
        code_q.push_back(it);
      end
    end else begin
      target = sb.min_cover + $urandom_range(0, 4);
      if ($urandom_range(0, 6) == 0) target = $urandom_range(1, target);
      len = add_instruction(1);
      while (len < target && len < 80) len += add_instruction(0);
    end
    flush_code();
  endtask

  initial begin
    int unsigned mc;
    int unsigned mw;
    int start_cnt;
    sb = new();
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_MIN_COVER;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.payload = '0;
    out_ch.ready = 1'b0;
    cycle_count = 0;
    sent_count = 0;
    hold_req = 0;
    hold_left = 0;
    stall_mode = 0;
    burst_left = 4;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed, reset limits (cover 5 in a 64 byte window)
    push_bytes(0, '{8'h90});                               // idle byte, ignored
    push_bytes(1, '{8'h06});                               // unhandled opcode
    push_bytes(1, '{8'h0F, 8'h38});                        // three-byte escape
    push_bytes(1, '{8'h0F, 8'h3A});
    push_bytes(1, '{8'h48, 8'hB8, 8'h01, 8'h02, 8'h03, 8'h04,
                   8'h05, 8'h06, 8'h07, 8'hFF});           // mov imm64 under rex.w
    push_bytes(1, '{8'hF6, 8'hC0, 8'h00, 8'h90, 8'h90});   // F6 counts imm8
    push_bytes(1, '{8'h8B, 8'h04, 8'h25, 8'h11, 8'h22, 8'h33, 8'h44}); // sib base 5
    push_bytes(1, '{8'h8B, 8'h05, 8'hAA, 8'hBB, 8'hCC, 8'hDD}); // rip-relative
    push_bytes(1, '{8'h66, 8'h05, 8'h00, 8'h00, 8'h00, 8'h80}); // 66h keeps imm32
    push_bytes(1, '{8'h90, 8'h90});                        // restart mid-scan
    push_bytes(1, '{8'h0F, 8'h85, 8'h00, 8'h00, 8'h00, 8'h00}); // rel32
    flush_code();
    set_limits(3, 3);                                      // window runs out
    push_bytes(1, '{8'hC7, 8'h00, 8'h01, 8'h02, 8'h03, 8'h04});
    flush_code();
    set_limits(0, 10);                                     // bad limits
    push_bytes(1, '{8'h90});
    flush_code();
    set_limits(10, 5);
    push_bytes(1, '{8'h90});
    flush_code();
    set_limits(3, 100);
    push_bytes(1, '{8'h90});
    flush_code();
    set_limits(127, 127);
    push_bytes(1, '{8'hFF});
    flush_code();

    // random phases over several limit settings, extremes first
    for (int ph = 0; ph < 12; ph++) begin
      case (ph)
        0: begin mc = 1; mw = 1; end
        1: begin mc = 1; mw = 64; end
        2: begin mc = 64; mw = 64; end
        3: begin mc = 5; mw = 64; end
        4: begin mc = 64; mw = 65; end
        default: begin
          mc = $urandom_range(1, 20);
          mw = $urandom_range(mc, 64);
          if ($urandom_range(0, 9) == 0) mc = $urandom_range(0, 127);
        end
      endcase
      set_limits(mc, mw);
      // long receiver hold-off while the sender keeps going
      if (ph == 3) hold_req = 1;
      start_cnt = sent_count;
      while (sent_count - start_cnt < PhaseBytes) random_scan();
    end

    drain();
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
